@@ design/hld_pkg.sv @@
// shared types, constants and register indexes for the heater load-drop detector
`default_nettype none
package hld_pkg;

  localparam int TEMP_W  = 20;
  localparam int SP_W    = 18;
  localparam int ERR_W   = 14;
  localparam int MATH_W  = 22;
  localparam int TICK_W  = 8;
  localparam int STAB_W  = 5;
  localparam int CONF_W  = 2;
  localparam int LOADT_W = 7;
  localparam int IDX_W   = 3;
  localparam int CFGD_W  = 18;

  localparam logic [TICK_W-1:0]  BLANK_TICKS    = 8'd120;
  localparam logic [STAB_W-1:0]  ARM_TICKS      = 5'd20;
  localparam logic [CONF_W-1:0]  CONFIRM_TICKS  = 2'd2;
  localparam logic [LOADT_W-1:0] MAX_LOAD_TICKS = 7'd90;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [IDX_W-1:0] REG_SETPOINT    = 3'd0;
  localparam logic [IDX_W-1:0] REG_DROP_THRESH = 3'd1;
  localparam logic [IDX_W-1:0] REG_ENTER_ERROR = 3'd2;
  localparam logic [IDX_W-1:0] REG_NEAR_BAND   = 3'd3;
  localparam logic [IDX_W-1:0] REG_ARM_ERROR   = 3'd4;
  localparam logic [IDX_W-1:0] REG_EXIT_ERROR  = 3'd5;
  localparam logic [IDX_W-1:0] REG_FLOOR_ERROR = 3'd6;

  localparam logic [SP_W-1:0]  SETPOINT_RST    = 18'd40000;
  localparam logic [ERR_W-1:0] DROP_THRESH_RST = 14'd45;
  localparam logic [ERR_W-1:0] ENTER_ERROR_RST = 14'd100;
  localparam logic [ERR_W-1:0] NEAR_BAND_RST   = 14'd800;
  localparam logic [ERR_W-1:0] ARM_ERROR_RST   = 14'd250;
  localparam logic [ERR_W-1:0] EXIT_ERROR_RST  = 14'd80;
  localparam logic [ERR_W-1:0] FLOOR_ERROR_RST = 14'd350;

  typedef struct packed {
    logic [SP_W-1:0]  setpoint;
    logic [ERR_W-1:0] drop_threshold;
    logic [ERR_W-1:0] enter_error;
    logic [ERR_W-1:0] near_band;
    logic [ERR_W-1:0] arm_error;
    logic [ERR_W-1:0] exit_error;
    logic [ERR_W-1:0] floor_error;
  } cfg_t;

  typedef struct packed {
    logic                     operation;
    logic signed [TEMP_W-1:0] temperature;
  } in_item_t;

  typedef struct packed {
    logic [7:0] status_flags;
    logic       load_active;
    logic       precharge_pulse;
    logic       floor_required;
  } out_item_t;

endpackage
`default_nettype wire

@@ design/hld_cfg.sv @@
// configuration register file
`default_nettype none
module hld_cfg
  import hld_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [CFGD_W-1:0] cfg_wdata,
  output cfg_t                   cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SETPOINT:    cfg_nxt.setpoint       = cfg_wdata;
        REG_DROP_THRESH: cfg_nxt.drop_threshold = cfg_wdata[ERR_W-1:0];
        REG_ENTER_ERROR: cfg_nxt.enter_error    = cfg_wdata[ERR_W-1:0];
        REG_NEAR_BAND:   cfg_nxt.near_band      = cfg_wdata[ERR_W-1:0];
        REG_ARM_ERROR:   cfg_nxt.arm_error      = cfg_wdata[ERR_W-1:0];
        REG_EXIT_ERROR:  cfg_nxt.exit_error     = cfg_wdata[ERR_W-1:0];
        REG_FLOOR_ERROR: cfg_nxt.floor_error    = cfg_wdata[ERR_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint       <= SETPOINT_RST;
      cfg_r.drop_threshold <= DROP_THRESH_RST;
      cfg_r.enter_error    <= ENTER_ERROR_RST;
      cfg_r.near_band      <= NEAR_BAND_RST;
      cfg_r.arm_error      <= ARM_ERROR_RST;
      cfg_r.exit_error     <= EXIT_ERROR_RST;
      cfg_r.floor_error    <= FLOOR_ERROR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ design/hld_core.sv @@
// detector state and the per-sample compare and counter logic
`default_nettype none
module hld_core
  import hld_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output out_item_t     result
);

  logic signed [TEMP_W-1:0] last_temp_r, last_temp_nxt;
  logic                     last_valid_r, last_valid_nxt;
  logic [TICK_W-1:0]        total_ticks_r, total_ticks_nxt;
  logic [STAB_W-1:0]        stable_ticks_r, stable_ticks_nxt;
  logic [CONF_W-1:0]        confirm_ticks_r, confirm_ticks_nxt;
  logic                     load_mode_r, load_mode_nxt;
  logic [LOADT_W-1:0]       load_ticks_r, load_ticks_nxt;

  logic signed [MATH_W-1:0] temp_x, last_x, sp_x, err, drop;
  logic signed [MATH_W-1:0] arm_x, enter_x, near_x, thr_x, exit_x, floor_x;
  logic ready, stable, armed, below, near, dropping, confirmed, pulse, load_now;
  logic [CONF_W-1:0]  conf_cnt;
  logic [LOADT_W-1:0] lt_inc;

  always_comb begin
    temp_x  = MATH_W'(item.temperature);
    last_x  = MATH_W'(last_temp_r);
    sp_x    = $signed({{(MATH_W-SP_W){1'b0}}, cfg.setpoint});
    arm_x   = $signed({{(MATH_W-ERR_W){1'b0}}, cfg.arm_error});
    enter_x = $signed({{(MATH_W-ERR_W){1'b0}}, cfg.enter_error});
    near_x  = $signed({{(MATH_W-ERR_W){1'b0}}, cfg.near_band});
    thr_x   = $signed({{(MATH_W-ERR_W){1'b0}}, cfg.drop_threshold});
    exit_x  = $signed({{(MATH_W-ERR_W){1'b0}}, cfg.exit_error});
    floor_x = $signed({{(MATH_W-ERR_W){1'b0}}, cfg.floor_error});

    err  = sp_x - temp_x;
    drop = last_x - temp_x;

    // tick counter stops one past the blanking count
    total_ticks_nxt = (total_ticks_r <= BLANK_TICKS) ? total_ticks_r + 1'b1 : total_ticks_r;
    ready    = total_ticks_nxt > BLANK_TICKS;
    stable   = (err > -arm_x) && (err < arm_x);
    below    = err > enter_x;
    near     = temp_x > (sp_x - near_x);
    dropping = last_valid_r && (drop > thr_x);

    if (ready && stable) begin
      stable_ticks_nxt = (stable_ticks_r < ARM_TICKS) ? stable_ticks_r + 1'b1 : stable_ticks_r;
    end else begin
      stable_ticks_nxt = '0;
    end
    armed = stable_ticks_nxt >= ARM_TICKS;

    if (armed && below && near && dropping) begin
      conf_cnt = (confirm_ticks_r < CONFIRM_TICKS) ? confirm_ticks_r + 1'b1 : confirm_ticks_r;
    end else begin
      conf_cnt = '0;
    end

    pulse    = !load_mode_r && (conf_cnt >= CONFIRM_TICKS);
    load_now = load_mode_r || pulse;
    confirmed = ((pulse ? '0 : conf_cnt) >= CONFIRM_TICKS) || load_now;

    lt_inc = (pulse ? '0 : load_ticks_r) + 1'b1;

    result.status_flags    = {load_now, confirmed, dropping, near,
                              below, armed, stable, ready};
    result.load_active     = load_now;
    result.precharge_pulse = pulse;
    result.floor_required  = load_now && (err > floor_x);

    confirm_ticks_nxt = pulse ? '0 : conf_cnt;
    if (load_now && ((err <= exit_x) || (lt_inc >= MAX_LOAD_TICKS))) begin
      load_mode_nxt  = 1'b0;
      load_ticks_nxt = '0;
    end else if (load_now) begin
      load_mode_nxt  = 1'b1;
      load_ticks_nxt = lt_inc;
    end else begin
      load_mode_nxt  = 1'b0;
      load_ticks_nxt = load_ticks_r;
    end
    last_temp_nxt  = item.temperature;
    last_valid_nxt = 1'b1;

    // restart wipes the detector and reports all zeros
    if (item.operation == OP_RESTART) begin
      result            = '0;
      total_ticks_nxt   = '0;
      stable_ticks_nxt  = '0;
      confirm_ticks_nxt = '0;
      load_mode_nxt     = 1'b0;
      load_ticks_nxt    = '0;
      last_temp_nxt     = '0;
      last_valid_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_temp_r     <= '0;
      last_valid_r    <= 1'b0;
      total_ticks_r   <= '0;
      stable_ticks_r  <= '0;
      confirm_ticks_r <= '0;
      load_mode_r     <= 1'b0;
      load_ticks_r    <= '0;
    end else if (step) begin
      last_temp_r     <= last_temp_nxt;
      last_valid_r    <= last_valid_nxt;
      total_ticks_r   <= total_ticks_nxt;
      stable_ticks_r  <= stable_ticks_nxt;
      confirm_ticks_r <= confirm_ticks_nxt;
      load_mode_r     <= load_mode_nxt;
      load_ticks_r    <= load_ticks_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/heater_load_drop_detector.sv @@
// Heater load-drop detector, top level. Takes one temperature sample (or a restart
// command) per transfer and returns one result per sample: eight status flags, the
// load-mode flag, an integral precharge pulse and a floor request. Throughput is one
// sample per clock cycle while the output is not stalled; each sample passes the input
// register, then the detector state update together with the result register, whose
// contents are then offered on the output.
// A stalled result holds the sample behind it, and the input stalls once both are full.
// Configuration writes take effect on the next cycle and should only be made while no
// sample is in flight.
`default_nettype none
module heater_load_drop_detector
  import hld_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [CFGD_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  in_item_t  item_r;
  logic      item_valid_r;
  out_item_t result, result_r;
  logic      result_valid_r;
  logic      advance;

  hld_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // result register frees up when empty or being taken
  assign advance  = !result_valid_r || out_ready;
  assign in_ready = !item_valid_r || advance;

  hld_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (item_valid_r && advance),
    .item   (item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r   <= 1'b0;
      result_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        item_valid_r <= in_valid;
      end
      if (advance) begin
        result_valid_r <= item_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (item_valid_r && advance) begin
      result_r <= result;
    end
  end

  assign out_valid = result_valid_r;
  assign out_data  = result_r;

  a_pulse_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.precharge_pulse |-> out_data.load_active && out_data.status_flags[7])
    else $error("precharge pulse outside load mode");

  a_floor_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.floor_required |-> out_data.load_active)
    else $error("floor request outside load mode");

  a_load_confirmed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.load_active |-> out_data.status_flags[6])
    else $error("load mode without confirmed flag");

  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r && !advance |=> item_valid_r && $stable(item_r))
    else $error("pending sample lost while result stalled");

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// testbench for the heater load-drop detector: stimulus, result checking and run control
`timescale 1ns / 1ps
module tb_top;
  import hld_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_REPORTS   = 10;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_pattern_e;
  typedef enum int {LOAD_HOVER, LOAD_SINK, LOAD_RECOVER} load_shape_e;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = REG_SETPOINT;
  logic [CFGD_W-1:0] cfg_wdata = '0;

  // register copy and detector state as the predictor sees them
  cfg_t                     active_cfg;
  logic signed [TEMP_W-1:0] prev_temp = '0;
  bit                       prev_valid = 1'b0;
  logic [TICK_W-1:0]        tick_count = '0;
  logic [STAB_W-1:0]        stable_count = '0;
  logic [CONF_W-1:0]        confirm_count = '0;
  bit                       in_load = 1'b0;
  logic [LOADT_W-1:0]       load_count = '0;

  in_item_t  sample_q[$];
  out_item_t expected_status_q[$];

  int  queued_total = 0;
  int  results_checked = 0;
  int  error_count = 0;
  int  quiet_cycles = 0;
  int  restarts_seen = 0;
  int  loads_entered = 0;
  int  floor_requests = 0;
  int  settings_applied = 0;
  int  hold_req = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  rx_left = 0;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;
  rx_pattern_e rx_pattern = RX_OPEN;

  heater_load_drop_detector DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int rand_between(input int lo, input int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic out_item_t detect_load_drop(input in_item_t item);
    out_item_t r;
    int sp, t, err, fall;
    bit ready, stable, armed, below, near_sp, dropping, confirmed, pulse;
    r = '0;
    if (item.operation == OP_RESTART) begin
      prev_temp = '0;
      prev_valid = 1'b0;
      tick_count = '0;
      stable_count = '0;
      confirm_count = '0;
      in_load = 1'b0;
      load_count = '0;
      restarts_seen++;
      return r;
    end
    sp = int'(active_cfg.setpoint);
    t = $signed(item.temperature);
    err = sp - t;
    fall = prev_valid ? int'($signed(prev_temp)) - t : 0;

    // blanking counter holds once past the start-up period
    if (tick_count <= BLANK_TICKS) tick_count++;
    ready = tick_count > BLANK_TICKS;
    stable = (err > -int'(active_cfg.arm_error)) && (err < int'(active_cfg.arm_error));
    below = err > int'(active_cfg.enter_error);
    near_sp = t > sp - int'(active_cfg.near_band);
    dropping = prev_valid && (fall > int'(active_cfg.drop_threshold));

    if (ready && stable) begin
      if (stable_count < ARM_TICKS) stable_count++;
    end else begin
      stable_count = '0;
    end
    armed = stable_count >= ARM_TICKS;

    if (armed && below && near_sp && dropping) begin
      if (confirm_count < CONFIRM_TICKS) confirm_count++;
    end else begin
      confirm_count = '0;
    end

    pulse = 1'b0;
    if (!in_load && confirm_count >= CONFIRM_TICKS) begin
      in_load = 1'b1;
      load_count = '0;
      confirm_count = '0;
      pulse = 1'b1;
      loads_entered++;
    end

    confirmed = (confirm_count >= CONFIRM_TICKS) || in_load;
    r.status_flags = {in_load, confirmed, dropping, near_sp, below, armed, stable, ready};
    r.load_active = in_load;
    r.precharge_pulse = pulse;
    r.floor_required = in_load && (err > int'(active_cfg.floor_error));
    floor_requests += r.floor_required;

    // flags above still show load on the sample that ends it
    if (in_load) begin
      load_count++;
      if (err <= int'(active_cfg.exit_error) || load_count >= MAX_LOAD_TICKS) begin
        in_load = 1'b0;
        load_count = '0;
      end
    end
    prev_temp = item.temperature;
    prev_valid = 1'b1;
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("mismatch on result %0d, %s: expected %b got %b",
                 results_checked, field, want, got);
    end
  endfunction

  // transfers are sampled here; predictions are made as inputs are taken
  always @(posedge clk) begin
    out_item_t want;
    in_taken = rst_n && in_valid && in_ready;
    out_taken = rst_n && out_valid && out_ready;
    if (in_taken) expected_status_q.push_back(detect_load_drop(in_data));
    if (out_taken) begin
      results_checked++;
      if (expected_status_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result %0d: %p", results_checked, out_data);
      end else begin
        want = expected_status_q.pop_front();
        check_field("status_flags", want.status_flags, out_data.status_flags);
        check_field("load_active", 8'(want.load_active), 8'(out_data.load_active));
        check_field("precharge_pulse", 8'(want.precharge_pulse),
                    8'(out_data.precharge_pulse));
        check_field("floor_required", 8'(want.floor_required),
                    8'(out_data.floor_required));
      end
    end
    if (in_taken || out_taken || cfg_we) quiet_cycles = 0;
    else quiet_cycles++;
  end

  // sender: bursts of transfers with random gaps between them
  always @(negedge clk) begin
    logic     launch;
    in_item_t next_item;
    launch = in_valid;
    next_item = in_data;
    if (!rst_n) begin
      launch = 1'b0;
    end else if (!in_valid || in_taken) begin
      launch = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (sample_q.size() != 0) begin
        next_item = sample_q.pop_front();
        launch = 1'b1;
        if (burst_left <= 1) begin
          burst_left = rand_between(1, 48);
          gap_left = ($urandom_range(2) == 0) ? 0 :
                     rand_between(1, ($urandom_range(5) == 0) ? 24 : 4);
        end else begin
          burst_left--;
        end
      end
    end
    in_valid <= launch;
    in_data <= next_item;
  end

  // receiver: stall pattern is redrawn at random intervals, long hold-off on request
  always @(negedge clk) begin
    logic take;
    if (hold_left == 0 && hold_served != hold_req) begin
      hold_served = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_e'($urandom_range(3));
      rx_left = rand_between(16, 96);
    end
    rx_left--;
    case (rx_pattern)
      RX_OPEN:   take = 1'b1;
      RX_COIN:   take = ($urandom_range(1) == 1);
      RX_SPARSE: take = ($urandom_range(3) == 0);
      default:   take = rx_left[0];
    endcase
    if (hold_left > 0) begin
      hold_left--;
      take = 1'b0;
    end
    out_ready <= take;
  end

  task automatic push_sample(input int t);
    in_item_t it;
    it.operation = OP_SAMPLE;
    it.temperature = t[TEMP_W-1:0];
    sample_q.push_back(it);
    queued_total++;
  endtask

  task automatic push_restart();
    in_item_t    it;
    logic [31:0] r;
    r = $urandom;
    it.operation = OP_RESTART;
    it.temperature = r[TEMP_W-1:0];
    sample_q.push_back(it);
    queued_total++;
  endtask

  // readings inside the arming window around the setpoint
  task automatic push_settled(input int n);
    int sp, hw;
    sp = int'(active_cfg.setpoint);
    hw = (active_cfg.arm_error > 0) ? int'(active_cfg.arm_error) - 1 : 0;
    repeat (n) push_sample(sp - rand_between(-hw, hw));
  endtask

  task automatic push_noise(input int n, input bit allow_restart);
    logic [31:0] r;
    repeat (n) begin
      r = $urandom;
      if (allow_restart && $urandom_range(24) == 0) push_restart();
      else if (r[31]) push_sample(int'(r));
      else push_sample(int'(active_cfg.setpoint) + rand_between(-2000, 2000));
    end
  endtask

  // arm, fall for a few samples, then a stretch of load behavior and recovery (or just noise)
  task automatic push_episode();
    int sp, thr, ent, hw, ex, flr, step, e, drops, len, pick;
    load_shape_e shape;
    sp = int'(active_cfg.setpoint);
    thr = int'(active_cfg.drop_threshold);
    ent = int'(active_cfg.enter_error);
    ex = int'(active_cfg.exit_error);
    flr = int'(active_cfg.floor_error);
    hw = (active_cfg.arm_error > 0) ? int'(active_cfg.arm_error) - 1 : 0;
    pick = $urandom_range(99);
    if (pick < 12) begin
      push_noise(rand_between(2, 8), 1'b0);
      return;
    end
    // a fall of exactly the threshold does not count as dropping
    step = (pick < 18) ? thr : thr + 1 + rand_between(0, 1 + thr / 4);
    drops = (pick >= 18 && pick < 28) ? 1 : rand_between(2, 4);
    e = ent + 1 - step + rand_between(0, 3);
    push_settled(int'(ARM_TICKS) - 1 + rand_between(0, 4));
    push_sample(sp - e);
    repeat (drops) begin
      e += step;
      push_sample(sp - e);
    end
    shape = load_shape_e'($urandom_range(2));
    len = ($urandom_range(3) == 0) ? rand_between(85, 100) : rand_between(1, 30);
    repeat (len) begin
      case (shape)
        LOAD_HOVER: push_sample(sp - rand_between(ex + 1, ex + 1 + 2 * flr));
        LOAD_SINK: begin
          e += rand_between(0, step);
          push_sample(sp - e);
        end
        default: push_sample(sp - rand_between(-hw, ex));
      endcase
    end
    repeat (rand_between(1, 3)) push_sample(sp - rand_between(-ex, ex));
  endtask

  function automatic logic [CFGD_W-1:0] pad_word(input logic [ERR_W-1:0] v);
    logic [31:0] junk;
    junk = $urandom;
    return {junk[CFGD_W-ERR_W-1:0], v};
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    int   sp, thr, ent, arm, band, ex, flr;
    sp = rand_between(1000, 150000);
    thr = rand_between(5, 300);
    ent = rand_between(20, 400);
    arm = ent + 3 * thr + rand_between(10, 500);
    band = arm + rand_between(0, 3000);
    ex = rand_between(0, ent);
    flr = rand_between(ent, arm + 1000);
    s.setpoint = SP_W'(sp);
    s.drop_threshold = ERR_W'(thr);
    s.enter_error = ERR_W'(ent);
    s.arm_error = ERR_W'(arm);
    s.near_band = ERR_W'(band);
    s.exit_error = ERR_W'(ex);
    s.floor_error = ERR_W'(flr);
    return s;
  endfunction

  // only called while idle; upper bits of the narrow registers carry junk
  task automatic apply_settings(input cfg_t s);
    logic [CFGD_W-1:0] word [0:REG_FLOOR_ERROR];
    logic [31:0]       r;
    word[REG_SETPOINT] = s.setpoint;
    word[REG_DROP_THRESH] = pad_word(s.drop_threshold);
    word[REG_ENTER_ERROR] = pad_word(s.enter_error);
    word[REG_NEAR_BAND] = pad_word(s.near_band);
    word[REG_ARM_ERROR] = pad_word(s.arm_error);
    word[REG_EXIT_ERROR] = pad_word(s.exit_error);
    word[REG_FLOOR_ERROR] = pad_word(s.floor_error);
    for (int i = int'(REG_SETPOINT); i <= int'(REG_FLOOR_ERROR); i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= i[IDX_W-1:0];
      cfg_wdata <= word[i[IDX_W-1:0]];
    end
    // unmapped index, must leave every register alone
    r = $urandom;
    @(negedge clk);
    cfg_index <= REG_UNUSED;
    cfg_wdata <= pad_word(r[ERR_W-1:0]);
    @(negedge clk);
    cfg_we <= 1'b0;
    active_cfg = s;
    settings_applied++;
  endtask

  task automatic wait_idle();
    while (results_checked < queued_total) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    cfg_t s;
    int   sp0;
    active_cfg = {SETPOINT_RST, DROP_THRESH_RST, ENTER_ERROR_RST, NEAR_BAND_RST,
                  ARM_ERROR_RST, EXIT_ERROR_RST, FLOOR_ERROR_RST};
    sp0 = int'(SETPOINT_RST);
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes and threshold edges under reset settings
    push_sample(-524288);
    push_sample(524287);
    push_sample(-524288);
    push_sample(-1);
    push_sample(0);
    push_sample(-50000);
    push_sample(300000);
    push_restart();
    push_sample(sp0 - int'(NEAR_BAND_RST));
    push_sample(sp0 - int'(NEAR_BAND_RST) + 1);
    push_sample(sp0 - int'(ENTER_ERROR_RST));
    push_sample(sp0 - int'(ENTER_ERROR_RST) - 1);
    push_sample(sp0 - int'(ENTER_ERROR_RST) - 1 - int'(DROP_THRESH_RST));
    push_sample(sp0 - int'(ENTER_ERROR_RST) - 2 - 2 * int'(DROP_THRESH_RST));
    push_sample(sp0 - int'(ARM_ERROR_RST));
    push_sample(sp0 + int'(ARM_ERROR_RST));
    push_sample(sp0 + int'(ARM_ERROR_RST) - 1);
    push_sample(sp0 - int'(EXIT_ERROR_RST));
    push_sample(sp0 - int'(FLOOR_ERROR_RST) - 1);
    push_restart();
    push_restart();
    push_sample(150000);
    wait_idle();

    // reset settings: full blanking, then drop episodes under a long output stall
    push_restart();
    push_settled(int'(BLANK_TICKS) + int'(ARM_TICKS) + 4);
    hold_req++;
    while (queued_total < 360) push_episode();
    wait_idle();

    s = '0;
    apply_settings(s);
    push_noise(50, 1'b1);
    wait_idle();

    s = '1;
    apply_settings(s);
    push_noise(30, 1'b1);
    while (queued_total < 500) push_episode();
    wait_idle();

    apply_settings(random_settings());
    push_restart();
    push_settled(int'(BLANK_TICKS) + int'(ARM_TICKS) + 4);
    while (queued_total < 780) push_episode();
    wait_idle();

    // detector state carries over the register change
    apply_settings(random_settings());
    hold_req++;
    while (queued_total < 1050) push_episode();
    wait_idle();

    $display("run: %0d items through %0d register settings beyond reset, %0d restarts",
             queued_total, settings_applied, restarts_seen);
    $display("detector: %0d load-mode entries, %0d floor requests, %0d mismatches",
             loads_entered, floor_requests, error_count);
    if (error_count == 0 && expected_status_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
